// ===== rtl/lhpt_pkg.sv =====
`timescale 1ns / 1ps

package lhpt_pkg;

  localparam int unsigned TableEntries = 4096;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned BlockShift   = 6;
  localparam int unsigned CtrW         = 2;

  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 8;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CtrW-1:0] ctr_t;

  localparam ctr_t CtrInit = 2'd2;
  localparam ctr_t CtrMax  = 2'd3;
  localparam ctr_t CtrMin  = 2'd0;

  localparam logic OpPredict = 1'b0;
  localparam logic OpUpdate  = 1'b1;

  // Hash of pc and block address; the table size is a power of two, so the
  // remainder is the low index bits.
  function automatic idx_t table_index(logic [63:0] pc, logic [63:0] address);
    logic [63:0] hash;
    hash = pc ^ (address >> BlockShift);
    return hash[IdxW-1:0];
  endfunction

  function automatic ctr_t ctr_step(ctr_t ctr, logic hit);
    ctr_t res;
    res = ctr;
    if (hit) begin
      if (ctr != CtrMax) res = ctr + 2'd1;
    end else begin
      if (ctr != CtrMin) res = ctr - 2'd1;
    end
    return res;
  endfunction

endpackage

// ===== rtl/lhpt_ram.sv =====
`timescale 1ns / 1ps

module lhpt_ram #(
  parameter int unsigned Width = 2,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // read-first: a read at the address being written returns the old word
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/load_hit_predictor_table.sv =====
`timescale 1ns / 1ps

// Load hit predictor: a table of 2-bit saturating counters held in one RAM
// (lhpt_pkg::TableEntries entries), indexed by pc XOR (address >> 6). A
// transaction with tuser = 0 asks for a prediction and returns one result
// (tdata bit 0 = predicted hit, 0 while disabled); tuser = 1 updates the
// counter with the outcome in tdata bit 128 while enabled and returns
// nothing. Every item is a RAM read into stage s1, which holds the counter
// logic and write-back, with the last written entry forwarded, so one item
// is taken per cycle while the result register drains; a prediction passes
// through s1 and then the result register that drives m_axis_tvalid_o.
// After reset the table is swept to "weakly hit", one entry per cycle:
// s_axis_tready_o stays low until all TableEntries (4096) are written.
// The enable register may be written at any time through the cfg channel,
// but only takes a defined effect while no item is in flight.
module load_hit_predictor_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_data_i,      // enabled
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [63:0] pc, [127:64] address, [128] actual_hit, [135:129] zero
  input  logic [lhpt_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic                          s_axis_tuser_i,  // opcode
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] predicted_hit, [7:1] zero
  output logic [lhpt_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned IdxW = lhpt_pkg::IdxW;

  logic enabled_q;
  logic [IdxW:0] clr_cnt_q, clr_cnt_d;
  logic init_done;

  logic s1_valid_q, s1_valid_d;
  logic s1_upd_q, s1_hit_q;
  lhpt_pkg::idx_t s1_idx_q;

  logic fwd_valid_q;
  lhpt_pkg::idx_t fwd_idx_q;
  lhpt_pkg::ctr_t fwd_val_q;

  logic out_valid_q, out_valid_d;
  logic out_hit_q, out_hit_d;

  logic in_fire, out_free, s1_adv, wr_upd;
  lhpt_pkg::idx_t in_idx, ram_waddr;
  lhpt_pkg::ctr_t ram_rdata, ram_wdata, ctr_cur, ctr_next;
  logic ram_we;

  assign init_done = clr_cnt_q[IdxW];
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign s1_adv    = s1_valid_q && (s1_upd_q || out_free);
  assign s_axis_tready_o = init_done && (!s1_valid_q || s1_adv);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_idx    = lhpt_pkg::table_index(s_axis_tdata_i[63:0], s_axis_tdata_i[127:64]);

  // the last write is the newest copy of its entry, and may have landed on
  // the same edge as this item's read
  assign ctr_cur  = (fwd_valid_q && fwd_idx_q == s1_idx_q) ? fwd_val_q : ram_rdata;
  assign ctr_next = lhpt_pkg::ctr_step(ctr_cur, s1_hit_q);
  assign wr_upd   = s1_valid_q && s1_upd_q && enabled_q;

  assign ram_we    = !init_done || wr_upd;
  assign ram_waddr = init_done ? s1_idx_q : clr_cnt_q[IdxW-1:0];
  assign ram_wdata = init_done ? ctr_next : lhpt_pkg::CtrInit;

  lhpt_ram #(
    .Width (lhpt_pkg::CtrW),
    .Depth (lhpt_pkg::TableEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire),
    .raddr_i (in_idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    clr_cnt_d = clr_cnt_q;
    if (!init_done) clr_cnt_d = clr_cnt_q + 1'b1;

    s1_valid_d = s1_valid_q;
    if (in_fire) s1_valid_d = 1'b1;
    else if (s1_adv) s1_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;
    if (s1_valid_q && !s1_upd_q && out_free) begin
      out_valid_d = 1'b1;
      out_hit_d   = enabled_q && ctr_cur[1];
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b1;
      clr_cnt_q   <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) enabled_q <= cfg_data_i;
      clr_cnt_q   <= clr_cnt_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (wr_upd) fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_upd_q <= (s_axis_tuser_i == lhpt_pkg::OpUpdate);
      s1_hit_q <= s_axis_tdata_i[128];
      s1_idx_q <= in_idx;
    end
    if (wr_upd) begin
      fwd_idx_q <= s1_idx_q;
      fwd_val_q <= ctr_next;
    end
    out_hit_q <= out_hit_d;
  end

  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(lhpt_pkg::OutDataW - 1){1'b0}}, out_hit_q};

endmodule

// ===== rtl/lhpt_checker.sv =====
`timescale 1ns / 1ps

module lhpt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [lhpt_pkg::OutDataW-1:0] m_axis_tdata_o
);

  // table sweep still running on the first cycle out of reset
  a_no_accept_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready_o)
    else $error("input ready during table clear");

  a_no_result_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid right after reset");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[lhpt_pkg::OutDataW-1:1] == '0)
    else $error("result padding bits not zero");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result transaction changed");

endmodule

bind load_hit_predictor_table lhpt_checker u_lhpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
